### hw/rtl/snptc_pkg.sv
// shared types, constants and helpers for the sector nearest point turn command block
package snptc_pkg;

   // cordic datapath widths: coordinates run at 40 fraction-adjusted bits, angles at rad*2^24
   localparam int XW = 43;
   localparam int ZW = 28;
   localparam int ATAN_DEPTH = 24;
   localparam int PART_W = 21;
   localparam int GAIN_W = 20;
   localparam int PROD_W = PART_W + GAIN_W;
   localparam int SUM_W = 63;

   localparam logic signed [ZW-1:0] PI_Z = 28'sd52707179;
   localparam logic signed [16:0] PI_Q13 = 17'sd25736;
   localparam logic signed [16:0] TWO_PI_Q13 = 17'sd51472;
   localparam logic signed [16:0] REACH_LIMIT = 17'sd82;
   localparam logic [15:0] MIN_DIST = 16'd10;
   localparam logic [15:0] MAX_DIST = 16'd65534;
   localparam logic [15:0] NO_POINT = 16'hFFFF;
   localparam logic [GAIN_W-1:0] INV_GAIN = 20'd636751;
   localparam logic signed [ZW-1:0] BEAR_ROUND = 28'sd1024;
   localparam logic signed [ZW-1:0] BEAR_MAX = 28'sd25736;

   localparam logic signed [ZW-1:0] ATAN_LUT [ATAN_DEPTH] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
      28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069,
      28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
      28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
      28'sd256, 28'sd128, 28'sd64, 28'sd32,
      28'sd16, 28'sd8, 28'sd4, 28'sd2
   };

   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = 2;
   localparam int FQ_CNT_W = 3;

   typedef enum logic [1:0] {
      REG_TARGET_ANGLE = 2'd0,
      REG_SECTOR_HALF  = 2'd1,
      REG_TURN_SPEED   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] target_angle;
      logic [14:0]        sector_half_width;
      logic signed [15:0] turn_speed;
   } cfg_type;

   // one classified point handed from the cordic front to the selection back end
   typedef struct packed {
      logic [15:0]        dist_mm;
      logic signed [15:0] bear;
      logic               in_sector;
      logic               scan_end;
   } point_type;

   // bring an angle difference back into [-pi, pi], one step is always enough
   function automatic logic signed [16:0] wrap_q13(input logic signed [16:0] d);
      logic signed [16:0] r;
      r = d;
      if (r > PI_Q13) begin
         r = r - TWO_PI_Q13;
      end
      if (r < -PI_Q13) begin
         r = r + TWO_PI_Q13;
      end
      return r;
   endfunction

endpackage

### hw/rtl/snptc_if.sv
// valid/ready channel interfaces for points in and turn results out
interface snptc_req_if #(
   parameter int COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          scan_end;

   modport source (output valid, output point_x, output point_y, output scan_end,
                   input ready);
   modport sink (input valid, input point_x, input point_y, input scan_end,
                 output ready);
endinterface

interface snptc_rsp_if;
   logic               valid;
   logic               ready;
   logic               reached;
   logic signed [15:0] rotation_command;
   logic [15:0]        nearest_distance;
   logic signed [15:0] nearest_bearing;

   modport source (output valid, output reached, output rotation_command,
                   output nearest_distance, output nearest_bearing, input ready);
   modport sink (input valid, input reached, input rotation_command,
                 input nearest_distance, input nearest_bearing, output ready);
endinterface

### hw/rtl/snptc_front.sv
// pipelined cordic front: bearing, distance, sector test, one point per unstalled cycle
module snptc_front import snptc_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   input  logic                          in_scan_end,
   input  cfg_type                       cfg,
   input  logic                          q_full,
   output logic                          out_valid,
   output point_type                     out_point
);

   localparam int FRAC = 40 - COORD_WIDTH;
   localparam int NVLD = CORDIC_STAGES + 3;

   logic en;

   logic [NVLD-1:0] vld_ff;
   logic [NVLD-1:0] vld_in;

   logic signed [XW-1:0] x_ff [CORDIC_STAGES+1];
   logic signed [XW-1:0] y_ff [CORDIC_STAGES+1];
   logic signed [ZW-1:0] z_ff [CORDIC_STAGES+1];
   logic                 end_ff [CORDIC_STAGES+1];
   logic signed [XW-1:0] x_in [CORDIC_STAGES+1];
   logic signed [XW-1:0] y_in [CORDIC_STAGES+1];
   logic signed [ZW-1:0] z_in [CORDIC_STAGES+1];

   logic signed [XW-1:0] px;
   logic signed [XW-1:0] py;

   // whole row advances together; it only holds when the queue cannot take the last stage
   assign en = !(vld_ff[NVLD-1] && q_full);
   assign in_ready = en;

   assign vld_in = {vld_ff[NVLD-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // pre-rotation into the right half plane
   assign px = XW'(in_x) <<< FRAC;
   assign py = XW'(in_y) <<< FRAC;

   always_comb begin
      if (px < 0) begin
         x_in[0] = -px;
         y_in[0] = -py;
         z_in[0] = (py >= 0) ? PI_Z : -PI_Z;
      end else begin
         x_in[0] = px;
         y_in[0] = py;
         z_in[0] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= x_in[0];
         y_ff[0] <= y_in[0];
         z_ff[0] <= z_in[0];
         end_ff[0] <= in_scan_end;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      always_comb begin
         if (y_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + ATAN_LUT[i];
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - ATAN_LUT[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1] <= x_in[i+1];
            y_ff[i+1] <= y_in[i+1];
            z_ff[i+1] <= z_in[i+1];
            end_ff[i+1] <= end_ff[i];
         end
      end
   end

   // first post stage: gain correction split into two partial products, bearing rounding
   logic [XW-2:0]          xc;
   logic signed [ZW-1:0]   zr;
   logic signed [15:0]     bear_in;
   logic [PROD_W-1:0]      ph_in;
   logic [PROD_W-1:0]      pl_in;
   logic [PROD_W-1:0]      ph_ff;
   logic [PROD_W-1:0]      pl_ff;
   logic signed [15:0]     bear1_ff;
   logic                   end1_ff;

   assign xc = (x_ff[CORDIC_STAGES] < 0) ? '0 : x_ff[CORDIC_STAGES][XW-2:0];
   assign ph_in = PROD_W'(xc[XW-2:PART_W]) * PROD_W'(INV_GAIN);
   assign pl_in = PROD_W'(xc[PART_W-1:0]) * PROD_W'(INV_GAIN);
   assign zr = (z_ff[CORDIC_STAGES] + BEAR_ROUND) >>> 11;

   always_comb begin
      if (zr > BEAR_MAX) begin
         bear_in = 16'(BEAR_MAX);
      end else if (zr < -BEAR_MAX) begin
         bear_in = 16'(-BEAR_MAX);
      end else begin
         bear_in = 16'(zr);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
         bear1_ff <= bear_in;
         end1_ff <= end_ff[CORDIC_STAGES];
      end
   end

   // second post stage: sum, round to mm, saturate, sector test
   logic [SUM_W-1:0]   sum;
   logic [SUM_W-1:0]   dscaled;
   logic [15:0]        dist_in;
   logic signed [16:0] diff;
   logic [16:0]        diff_abs;
   point_type          pt_in;
   point_type          pt_ff;

   assign sum = (SUM_W'(ph_ff) << PART_W) + SUM_W'(pl_ff) + (SUM_W'(1) << (19 + FRAC));
   assign dscaled = sum >> (20 + FRAC);
   assign dist_in = (dscaled > SUM_W'(MAX_DIST)) ? MAX_DIST : dscaled[15:0];

   assign diff = wrap_q13(17'(cfg.target_angle) - 17'(bear1_ff));
   assign diff_abs = (diff < 0) ? 17'(-diff) : 17'(diff);

   always_comb begin
      pt_in.dist_mm = dist_in;
      pt_in.bear = bear1_ff;
      pt_in.in_sector = diff_abs < 17'(cfg.sector_half_width);
      pt_in.scan_end = end1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff <= pt_in;
      end
   end

   assign out_valid = vld_ff[NVLD-1];
   assign out_point = pt_ff;

endmodule

### hw/rtl/snptc_queue.sv
// short register queue between the cordic front and the selection back end
module snptc_queue import snptc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  point_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output point_type head
);

   point_type            mem_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]  wr_ff;
   logic [FQ_PTR_W-1:0]  wr_in;
   logic [FQ_PTR_W-1:0]  rd_ff;
   logic [FQ_PTR_W-1:0]  rd_in;
   logic [FQ_CNT_W-1:0]  cnt_ff;
   logic [FQ_CNT_W-1:0]  cnt_in;

   assign full = (cnt_ff == FQ_CNT_W'(FQ_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head = mem_ff[rd_ff];

   assign wr_in = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in = pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + FQ_CNT_W'(push) - FQ_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/snptc_back.sv
// back end: keeps the nearest point of a scan and forms the turn result at scan end
module snptc_back import snptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  point_type          q_head,
   output logic               q_pop,
   input  cfg_type            cfg,
   output logic               out_valid,
   input  logic               out_ready,
   output logic               out_reached,
   output logic signed [15:0] out_rotation,
   output logic [15:0]        out_distance,
   output logic signed [15:0] out_bearing
);

   logic [15:0]        best_dist_ff;
   logic [15:0]        best_dist_in;
   logic signed [15:0] best_bear_ff;
   logic signed [15:0] best_bear_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               reached_ff;
   logic signed [15:0] rot_ff;
   logic [15:0]        dist_ff;
   logic signed [15:0] bear_ff;

   logic               take;
   logic [15:0]        nd;
   logic signed [15:0] nb;
   logic signed [16:0] err;
   logic               reached;
   logic signed [15:0] rot;
   logic               emit;

   // a scan-end point waits until the result register is free
   assign q_pop = q_valid && (!q_head.scan_end || !rsp_valid_ff || out_ready);
   assign emit = q_pop && q_head.scan_end;

   assign take = q_head.in_sector && (q_head.dist_mm > MIN_DIST) &&
                 (q_head.dist_mm < best_dist_ff);
   assign nd = take ? q_head.dist_mm : best_dist_ff;
   assign nb = take ? q_head.bear : best_bear_ff;

   assign err = wrap_q13(17'(cfg.target_angle) - 17'(nb));
   assign reached = (err < REACH_LIMIT) && (err > -REACH_LIMIT);

   always_comb begin
      if (reached) begin
         rot = '0;
      end else if (err > 0) begin
         rot = cfg.turn_speed;
      end else if (cfg.turn_speed == 16'sh8000) begin
         rot = 16'sh7FFF;
      end else begin
         rot = -cfg.turn_speed;
      end
   end

   always_comb begin
      best_dist_in = best_dist_ff;
      best_bear_in = best_bear_ff;
      if (emit) begin
         best_dist_in = NO_POINT;
         best_bear_in = '0;
      end else if (q_pop) begin
         best_dist_in = nd;
         best_bear_in = nb;
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_dist_ff <= NO_POINT;
         best_bear_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_dist_ff <= best_dist_in;
         best_bear_ff <= best_bear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         reached_ff <= reached;
         rot_ff <= rot;
         dist_ff <= nd;
         bear_ff <= nb;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_reached = reached_ff;
   assign out_rotation = rot_ff;
   assign out_distance = dist_ff;
   assign out_bearing = bear_ff;

endmodule

### hw/rtl/sector_nearest_point_turn_command_top.sv
// top level of the sector nearest point turn command block
//
//  channel  | direction | handshake         | beat
//  req_ch   | in        | valid/ready       | point_x, point_y, scan_end
//  rsp_ch   | out       | valid/ready       | reached, rotation_command, nearest_distance,
//           |           |                   | nearest_bearing (one beat per scan end)
//  csr_*    | in        | csr_we, no ready  | csr_index, csr_wdata
//
// one point a cycle while the front end is not stalled; a point passes through the
// pre-rotation register, the cordic row and two gain/rounding stages to the back end.
// the result beat is valid in the cycle after its scan-end point leaves the queue.
// reset clears the pipeline valids, the queue, the kept point and the result valid.
// a stalled result holds the back end at the next scan-end point; the queue then
// fills and req_ch.ready drops only when the last front-end stage cannot move on.
module sector_nearest_point_turn_command_top import snptc_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   snptc_req_if.sink   req_ch,
   snptc_rsp_if.source rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      q_full;
   logic      q_valid;
   logic      q_pop;
   logic      front_valid;
   logic      push;
   point_type front_point;
   point_type q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_TARGET_ANGLE: cfg_in.target_angle = csr_wdata;
            REG_SECTOR_HALF:  cfg_in.sector_half_width = csr_wdata[14:0];
            REG_TURN_SPEED:   cfg_in.turn_speed = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_angle <= '0;
         cfg_ff.sector_half_width <= 15'd4096;
         cfg_ff.turn_speed <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   snptc_front #(
      .COORD_WIDTH   (COORD_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .in_x        (req_ch.point_x),
      .in_y        (req_ch.point_y),
      .in_scan_end (req_ch.scan_end),
      .cfg         (cfg_ff),
      .q_full      (q_full),
      .out_valid   (front_valid),
      .out_point   (front_point)
   );

   assign push = front_valid && !q_full;

   snptc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_point),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head)
   );

   snptc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .cfg          (cfg_ff),
      .out_valid    (rsp_ch.valid),
      .out_ready    (rsp_ch.ready),
      .out_reached  (rsp_ch.reached),
      .out_rotation (rsp_ch.rotation_command),
      .out_distance (rsp_ch.nearest_distance),
      .out_bearing  (rsp_ch.nearest_bearing)
   );

endmodule

### hw/rtl/snptc_checker.sv
// port-level checks on the result channel, bound to the top level
module snptc_checker import snptc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_reached,
   input logic signed [15:0] rsp_rotation,
   input logic [15:0]        rsp_distance,
   input logic signed [15:0] rsp_bearing
);

   // a stalled result beat stays and keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reached) &&
         $stable(rsp_rotation) && $stable(rsp_distance) && $stable(rsp_bearing))
      else $error("result beat changed while stalled");

   a_reached_no_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reached |-> rsp_rotation == 16'sd0)
      else $error("turn command issued although reached");

   // no accepted point leaves the bearing at zero
   a_empty_bearing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_distance == NO_POINT |-> rsp_bearing == 16'sd0)
      else $error("bearing set without an accepted point");

   a_min_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance > MIN_DIST)
      else $error("nearest distance within the minimum range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sector_nearest_point_turn_command_top snptc_checker u_snptc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_reached  (rsp_ch.reached),
   .rsp_rotation (rsp_ch.rotation_command),
   .rsp_distance (rsp_ch.nearest_distance),
   .rsp_bearing  (rsp_ch.nearest_bearing)
);
